>>> hdl/prd_pkg.sv
// Shared types and constants of the pinhole ray direction pipeline.
// No dependencies; used by prd_isqrt, prd_div and pinhole_ray_direction.
package prd_pkg;

  // Normalized component magnitudes carry this many significant bits.
  localparam int NORM_BITS = 30;
  // Camera-frame magnitude: 17-bit |offset| times 20-bit pitch.
  localparam int MAG_W     = 37;
  localparam int LEN_W     = 6;
  // Sum of three squared normalized magnitudes.
  localparam int SQ_W      = 2 * NORM_BITS + 2;
  localparam int ROOT_W    = NORM_BITS + 1;
  localparam int ROW_W     = 48;
  localparam int ELEM_W    = 16;
  localparam int RES_W     = 13;
  localparam int LEN20_W   = 20;
  localparam int CFG_IDX_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_ROW0     = 8'd0,
    CFG_ROT_ROW1     = 8'd1,
    CFG_ROT_ROW2     = 8'd2,
    CFG_RESOLUTION_X = 8'd3,
    CFG_RESOLUTION_Y = 8'd4,
    CFG_PITCH_X      = 8'd5,
    CFG_PITCH_Y      = 8'd6,
    CFG_FOCAL_LENGTH = 8'd7
  } cfg_idx_t;

  // Travels beside the square root.
  typedef struct packed {
    logic [2:0][NORM_BITS-1:0] mag;
    logic [1:0]                neg;
    logic                      zero;
  } sq_side_t;

  // Travels beside the dividers.
  typedef struct packed {
    logic [1:0] neg;
    logic       zero;
  } div_side_t;

endpackage

>>> hdl/prd_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on prd_pkg (widths, sq_side_t).
module prd_isqrt import prd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_x,
  input  sq_side_t          in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output sq_side_t          out_side
);

  localparam int NS = ROOT_W;
  localparam int TW = SQ_W + 2;

  logic [SQ_W-1:0]   rem_r  [NS-1];
  logic [ROOT_W-1:0] root_r [NS];
  logic              vld_r  [NS];
  sq_side_t          side_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int B = NS - 1 - s;
    logic [SQ_W-1:0]   rem_in;
    logic [ROOT_W-1:0] root_in;
    logic              v_in;
    sq_side_t          side_in;
    logic [TW-1:0]     trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in  = in_x;
      assign root_in = '0;
      assign v_in    = in_valid;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign v_in    = vld_r[s-1];
      assign side_in = side_r[s-1];
    end

    // bit B of the root is set when rem >= (2*root + 2^B) * 2^B
    always_comb begin
      trial = ((TW'(root_in) << 1) + (TW'(1) << B)) << B;
      ge    = TW'(rem_in) >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= v_in;
      end
      if (en) begin
        root_r[s] <= ge ? (root_in | (ROOT_W'(1) << B)) : root_in;
        side_r[s] <= side_in;
      end
    end

    if (s < NS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= ge ? (rem_in - trial[SQ_W-1:0]) : rem_in;
        end
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_root  = root_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

>>> hdl/prd_div.sv
// Pipelined restoring divider, three numerators over one shared divisor.
// Depends on prd_pkg (widths, div_side_t).
module prd_div import prd_pkg::*; #(
  parameter int FRAC = 14
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [2:0][NORM_BITS+FRAC:0]         in_num,
  input  logic [ROOT_W-1:0]                    in_den,
  input  div_side_t                            in_side,
  output logic                                 out_valid,
  output logic [2:0][FRAC:0]                   out_q,
  output div_side_t                            out_side
);

  localparam int NUM_W = NORM_BITS + FRAC + 1;
  localparam int Q_W   = FRAC + 1;
  localparam int NS    = Q_W;
  localparam int CW    = NUM_W + 1;

  logic [2:0][NUM_W-1:0] rem_r  [NS-1];
  logic [ROOT_W-1:0]     den_r  [NS-1];
  logic [2:0][Q_W-1:0]   q_r    [NS];
  logic                  vld_r  [NS];
  div_side_t             side_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int B = NS - 1 - s;
    logic [2:0][NUM_W-1:0] rem_in;
    logic [ROOT_W-1:0]     den_in;
    logic [2:0][Q_W-1:0]   q_in;
    logic                  v_in;
    div_side_t             side_in;
    logic [CW-1:0]         trial;
    logic [2:0][NUM_W-1:0] rem_nxt;
    logic [2:0][Q_W-1:0]   q_nxt;

    if (s == 0) begin : g_first
      assign rem_in  = in_num;
      assign den_in  = in_den;
      assign q_in    = '0;
      assign v_in    = in_valid;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign den_in  = den_r[s-1];
      assign q_in    = q_r[s-1];
      assign v_in    = vld_r[s-1];
      assign side_in = side_r[s-1];
    end

    always_comb begin
      trial = CW'(den_in) << B;
      for (int j = 0; j < 3; j++) begin
        if (CW'(rem_in[j]) >= trial) begin
          rem_nxt[j] = rem_in[j] - trial[NUM_W-1:0];
          q_nxt[j]   = q_in[j] | (Q_W'(1) << B);
        end else begin
          rem_nxt[j] = rem_in[j];
          q_nxt[j]   = q_in[j];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= v_in;
      end
      if (en) begin
        q_r[s]    <= q_nxt;
        side_r[s] <= side_in;
      end
    end

    if (s < NS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_nxt;
          den_r[s] <= den_in;
        end
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_q     = q_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

>>> hdl/pinhole_ray_direction.sv
// Pinhole camera ray direction: pixel (u,v) to unit world direction, Q2.14.
// Depends on prd_pkg, prd_isqrt and prd_div.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+----------------
//  in      | in_u_coord, in_v_coord                  | in_valid/in_stall
//  out     | out_dir_x, out_dir_y, out_dir_z         | out_valid/out_stall
//  cfg     | cfg_index, cfg_data                     | cfg_valid/cfg_ready
//
// One request per cycle while the output is not stalled; the pipe holds
// the 31-stage square root and the DIR_FRAC_BITS+1 divider stages.
// All stages advance together; a stalled output holds the whole pipe.
// rst_n clears valid bits and loads the identity camera setup.
// cfg_ready is always high; writes beyond register 7 are dropped.
module pinhole_ray_direction import prd_pkg::*; #(
  parameter int MAX_RESOLUTION = 4096,
  parameter int DIR_FRAC_BITS  = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [15:0]          in_u_coord,
  input  logic [15:0]          in_v_coord,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_dir_x,
  output logic signed [15:0]   out_dir_y,
  output logic signed [15:0]   out_dir_z,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0]     cfg_data
);

  localparam int F     = DIR_FRAC_BITS;
  localparam int NUM_W = NORM_BITS + F + 1;
  localparam int Q_W   = F + 1;
  localparam int D_W   = F + 2;
  localparam int P_W   = ELEM_W + D_W;
  localparam int A_W   = P_W + 2;
  localparam int R_W   = A_W - F;

  // configuration
  logic [ROW_W-1:0]   rot_r [3];
  logic [RES_W-1:0]   res_x_r, res_y_r;
  logic [LEN20_W-1:0] pitch_x_r, pitch_y_r, focal_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0]  <= ROW_W'(48'h0000_0000_4000);
      rot_r[1]  <= ROW_W'(48'h0000_4000_0000);
      rot_r[2]  <= ROW_W'(48'h4000_0000_0000);
      res_x_r   <= RES_W'(1024);
      res_y_r   <= RES_W'(1024);
      pitch_x_r <= LEN20_W'(5243);
      pitch_y_r <= LEN20_W'(5243);
      focal_r   <= LEN20_W'(204800);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROT_ROW0:     rot_r[0]  <= cfg_data;
        CFG_ROT_ROW1:     rot_r[1]  <= cfg_data;
        CFG_ROT_ROW2:     rot_r[2]  <= cfg_data;
        CFG_RESOLUTION_X: res_x_r   <= cfg_data[RES_W-1:0];
        CFG_RESOLUTION_Y: res_y_r   <= cfg_data[RES_W-1:0];
        CFG_PITCH_X:      pitch_x_r <= cfg_data[LEN20_W-1:0];
        CFG_PITCH_Y:      pitch_y_r <= cfg_data[LEN20_W-1:0];
        CFG_FOCAL_LENGTH: focal_r   <= cfg_data[LEN20_W-1:0];
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  logic en;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // stage 1: offsets from the image center
  logic [RES_W-1:0]   rcx, rcy;
  logic signed [17:0] dx, dy;
  logic               v1_r;
  logic [16:0]        ax_r, ay_r;
  logic [1:0]         neg1_r;

  always_comb begin
    rcx = ({19'd0, res_x_r} > 32'(MAX_RESOLUTION)) ? RES_W'(MAX_RESOLUTION) : res_x_r;
    rcy = ({19'd0, res_y_r} > 32'(MAX_RESOLUTION)) ? RES_W'(MAX_RESOLUTION) : res_y_r;
    dx  = signed'({2'b00, in_u_coord}) - signed'({2'b00, rcx, 3'b000});
    dy  = signed'({2'b00, rcy, 3'b000}) - signed'({2'b00, in_v_coord});
  end

  // stage 2: scale by pixel pitch
  logic             v2_r;
  logic [MAG_W-1:0] m2_r [3];
  logic [1:0]       neg2_r;

  // stage 3: largest magnitude and its bit length
  logic             v3_r;
  logic [MAG_W-1:0] m3_r [3];
  logic [1:0]       neg3_r;
  logic [LEN_W-1:0] len_nxt, len3_r;
  logic [MAG_W-1:0] mx;
  logic             zero3_r;

  always_comb begin
    mx = m2_r[0];
    if (m2_r[1] > mx) mx = m2_r[1];
    if (m2_r[2] > mx) mx = m2_r[2];
    len_nxt = '0;
    for (int k = 0; k < MAG_W; k++) begin
      if (mx[k]) len_nxt = LEN_W'(k + 1);
    end
  end

  // stage 4: normalize to NORM_BITS significant bits
  logic                 v4_r;
  logic [NORM_BITS-1:0] n4_r [3];
  logic [1:0]           neg4_r;
  logic                 zero4_r;
  logic [MAG_W-1:0]     sh [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (len3_r > LEN_W'(NORM_BITS)) sh[i] = m3_r[i] >> (len3_r - LEN_W'(NORM_BITS));
      else                            sh[i] = m3_r[i] << (LEN_W'(NORM_BITS) - len3_r);
    end
  end

  // stage 5: squares
  logic                     v5_r;
  logic [NORM_BITS-1:0]     n5_r [3];
  logic [2*NORM_BITS-1:0]   sq5_r [3];
  logic [1:0]               neg5_r;
  logic                     zero5_r;

  // stage 6: sum of squares
  logic            v6_r;
  logic [SQ_W-1:0] s6_r;
  sq_side_t        side6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
    if (en) begin
      ax_r   <= dx[17] ? 17'(-dx) : dx[16:0];
      ay_r   <= dy[17] ? 17'(-dy) : dy[16:0];
      neg1_r <= {dy[17], dx[17]};

      m2_r[0] <= ax_r * pitch_x_r;
      m2_r[1] <= ay_r * pitch_y_r;
      m2_r[2] <= {5'd0, focal_r, 12'd0};
      neg2_r  <= neg1_r;

      m3_r    <= m2_r;
      len3_r  <= len_nxt;
      zero3_r <= (mx == '0);
      neg3_r  <= neg2_r;

      for (int i = 0; i < 3; i++) n4_r[i] <= sh[i][NORM_BITS-1:0];
      neg4_r  <= neg3_r;
      zero4_r <= zero3_r;

      for (int i = 0; i < 3; i++) sq5_r[i] <= n4_r[i] * n4_r[i];
      n5_r    <= n4_r;
      neg5_r  <= neg4_r;
      zero5_r <= zero4_r;

      s6_r <= SQ_W'(sq5_r[0]) + SQ_W'(sq5_r[1]) + SQ_W'(sq5_r[2]);
      side6_r.mag  <= {n5_r[2], n5_r[1], n5_r[0]};
      side6_r.neg  <= neg5_r;
      side6_r.zero <= zero5_r;
    end
  end

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  sq_side_t          sq_side;

  prd_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v6_r),
    .in_x      (s6_r),
    .in_side   (side6_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // stage 7: rounded numerators
  logic                  v7_r;
  logic [2:0][NUM_W-1:0] num7_r;
  logic [ROOT_W-1:0]     den7_r;
  div_side_t             side7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= sq_valid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num7_r[i] <= (NUM_W'(sq_side.mag[i]) << F) + NUM_W'(sq_root >> 1);
      end
      den7_r       <= sq_root;
      side7_r.neg  <= sq_side.neg;
      side7_r.zero <= sq_side.zero;
    end
  end

  logic                div_valid;
  logic [2:0][Q_W-1:0] div_q;
  div_side_t           div_side;

  prd_div #(.FRAC(F)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v7_r),
    .in_num    (num7_r),
    .in_den    (den7_r),
    .in_side   (side7_r),
    .out_valid (div_valid),
    .out_q     (div_q),
    .out_side  (div_side)
  );

  // stage 8: signed unit vector times rotation elements
  logic signed [D_W-1:0] d_vec [3];
  logic                  v8_r;
  logic signed [P_W-1:0] prod_r [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (div_side.zero)                  d_vec[i] = '0;
      else if (i == 2 || div_side.neg[i]) d_vec[i] = -signed'(D_W'(div_q[i]));
      else                                d_vec[i] = signed'(D_W'(div_q[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (en) begin
      v8_r <= div_valid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i][j] <= signed'(rot_r[i][ELEM_W*j +: ELEM_W]) * d_vec[i];
        end
      end
    end
  end

  // stage 9: column sums, rounding and saturation
  logic signed [A_W-1:0] acc [3];
  logic [A_W-1:0]        amag [3];
  logic [R_W-1:0]        rmag [3];
  logic signed [15:0]    dir_nxt [3];
  logic signed [15:0]    dir_r [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc[j]  = A_W'(prod_r[0][j]) + A_W'(prod_r[1][j]) + A_W'(prod_r[2][j]);
      amag[j] = acc[j][A_W-1] ? A_W'(-acc[j]) : A_W'(acc[j]);
      // half up for positive sums, half toward zero for negative ones
      rmag[j] = R_W'((amag[j] + (A_W'(1) << (F - 1)) - A_W'(acc[j][A_W-1])) >> F);
      if (acc[j][A_W-1]) begin
        dir_nxt[j] = (rmag[j] > R_W'(32768)) ? 16'sh8000 : 16'(-signed'(rmag[j]));
      end else begin
        dir_nxt[j] = (rmag[j] > R_W'(32767)) ? 16'sh7FFF : 16'(rmag[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v8_r;
    end
    if (en) begin
      dir_r <= dir_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_dir_x = dir_r[0];
  assign out_dir_y = dir_r[1];
  assign out_dir_z = dir_r[2];

  // nothing enters while a finished request is held
  a_no_accept_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("request accepted while output held");

  // a nonzero vector normalizes to a root with bit NORM_BITS-1 or above set
  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_valid && !sq_side.zero) |-> (sq_root[ROOT_W-1:ROOT_W-2] != 2'b00))
    else $error("square root out of normalized range");

  // unit components never exceed one
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (div_valid && !div_side.zero) |->
      (div_q[0] <= (Q_W'(1) << F)) && (div_q[1] <= (Q_W'(1) << F)) &&
      (div_q[2] <= (Q_W'(1) << F)))
    else $error("normalized component above one");

endmodule

>>> verif/tb_pinhole_ray_direction.sv
// Testbench for pinhole_ray_direction: random and directed pixel requests,
// predicted directions checked in order. Depends on prd_pkg and the RTL.
`timescale 1ns / 100ps

module tb_pinhole_ray_direction;
  import prd_pkg::*;

  localparam int PIPE_LAT = 55;
  localparam int WD_LIMIT = 20000;

  typedef struct {
    logic signed [15:0] x, y, z;
  } ray_dir_t;

  // Camera setup mirror and ray predictor.
  class ray_scoreboard;
    logic [47:0] rot [3];
    logic [12:0] res_x, res_y;
    logic [19:0] pit_x, pit_y, focal;
    ray_dir_t pending[$];
    int errors;

    function void reset_setup();
      rot[0] = 48'd16384; rot[1] = 48'd1 << 30; rot[2] = 48'd1 << 46;
      res_x = 13'd1024; res_y = 13'd1024;
      pit_x = 20'd5243; pit_y = 20'd5243; focal = 20'd204800;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [47:0] val);
      case (idx)
        CFG_ROT_ROW0: rot[0] = val;
        CFG_ROT_ROW1: rot[1] = val;
        CFG_ROT_ROW2: rot[2] = val;
        CFG_RESOLUTION_X: res_x = val[12:0];
        CFG_RESOLUTION_Y: res_y = val[12:0];
        CFG_PITCH_X: pit_x = val[19:0];
        CFG_PITCH_Y: pit_y = val[19:0];
        CFG_FOCAL_LENGTH: focal = val[19:0];
        default: ;
      endcase
    endfunction

    function longint unsigned root64(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else r = r >> 1;
        b = b >> 2;
      end
      return r;
    endfunction

    function logic signed [15:0] round_sat(longint signed acc);
      longint signed r;
      if (acc >= 0) r = (acc + 8192) >>> 14;
      else r = -((-acc + 8191) >>> 14);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
    endfunction

    function void note_request(logic [15:0] u, logic [15:0] v);
      longint signed dx, dy, cx, cy, acc;
      longint unsigned mag [3], top, sq, root, q;
      longint signed unit [3];
      logic neg [3];
      logic signed [15:0] e;
      int len;
      ray_dir_t res;
      cx = (res_x > 4096) ? 4096 : res_x;
      cy = (res_y > 4096) ? 4096 : res_y;
      dx = longint'(u) - cx * 8;
      dy = cy * 8 - longint'(v);
      neg[0] = dx < 0; neg[1] = dy < 0; neg[2] = 1'b1;
      mag[0] = (dx < 0 ? -dx : dx) * pit_x;
      mag[1] = (dy < 0 ? -dy : dy) * pit_y;
      mag[2] = longint'(focal) << 12;
      top = mag[0];
      if (mag[1] > top) top = mag[1];
      if (mag[2] > top) top = mag[2];
      if (top == 0) begin
        for (int i = 0; i < 3; i++) unit[i] = 0;
      end else begin
        len = 0;
        while (top != 0) begin
          len++;
          top = top >> 1;
        end
        sq = 0;
        for (int i = 0; i < 3; i++) begin
          if (len > 30) mag[i] = mag[i] >> (len - 30);
          else mag[i] = mag[i] << (30 - len);
          sq += mag[i] * mag[i];
        end
        root = root64(sq);
        for (int i = 0; i < 3; i++) begin
          q = ((mag[i] << 14) + (root >> 1)) / root;
          unit[i] = neg[i] ? -longint'(q) : longint'(q);
        end
      end
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int i = 0; i < 3; i++) begin
          e = rot[i][16*j +: 16];
          acc += longint'(e) * unit[i];
        end
        // rounded to Q2.14 then saturated
        if (j == 0) res.x = round_sat(acc);
        else if (j == 1) res.y = round_sat(acc);
        else res.z = round_sat(acc);
      end
      pending.push_back(res);
    endfunction

    function void check_result(logic signed [15:0] x, y, z);
      ray_dir_t exp_d;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %0d %0d %0d", $time, x, y, z);
        errors++;
        return;
      end
      exp_d = pending.pop_front();
      if (x !== exp_d.x) begin
        $display("%0t: dir_x expected %0d actual %0d", $time, exp_d.x, x);
        errors++;
      end
      if (y !== exp_d.y) begin
        $display("%0t: dir_y expected %0d actual %0d", $time, exp_d.y, y);
        errors++;
      end
      if (z !== exp_d.z) begin
        $display("%0t: dir_z expected %0d actual %0d", $time, exp_d.z, z);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall;
  logic [15:0] in_u_coord = 0, in_v_coord = 0;
  logic out_valid, out_stall = 0;
  logic signed [15:0] out_dir_x, out_dir_y, out_dir_z;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [ROW_W-1:0] cfg_data = 0;

  ray_scoreboard sb = new();
  int send_idle_pct = 0, stall_pct = 0;
  bit hold_off = 0;
  int quiet = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  pinhole_ray_direction DUT (.*);

  // monitor, scoreboard and watchdog on the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_u_coord, in_v_coord);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_dir_x, out_dir_y, out_dir_z);
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WD_LIMIT) begin
      $display("tb_pinhole_ray_direction: errors");
      $finish;
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // a pending register write ends here; valid stays up between requests unless idle cycles are drawn
  task automatic send_pixel(logic [15:0] u, logic [15:0] v);
    cfg_valid <= 0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_u_coord <= u;
    in_v_coord <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 5) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [47:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  task automatic send_random(int count);
    logic [15:0] u, v;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(3) == 0) begin
        u = 16'($urandom());
        v = 16'($urandom());
      end else begin
        // mostly inside the image
        u = 16'($urandom_range(sb.res_x > 4096 ? 65535 : sb.res_x * 16));
        v = 16'($urandom_range(sb.res_y > 4096 ? 65535 : sb.res_y * 16));
      end
      send_pixel(u, v);
    end
  endtask

  task automatic random_setup();
    logic [47:0] r;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(2))
        0: r = 48'd16384 << (16 * i);
        1: r = rand48();
        default: r = {16'($urandom_range(32767)), 16'(-$urandom_range(32767)),
                      16'($urandom_range(16384))};
      endcase
      write_cfg(cfg_idx_t'(i), r);
    end
    write_cfg(CFG_RESOLUTION_X, 48'($urandom_range(1, 8191)));
    write_cfg(CFG_RESOLUTION_Y, 48'($urandom_range(1, 4096)));
    write_cfg(CFG_PITCH_X, 48'($urandom_range(0, 20'hFFFFF)));
    write_cfg(CFG_PITCH_Y, 48'($urandom_range(1, 20'hFFFFF)));
    write_cfg(CFG_FOCAL_LENGTH,
              48'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20'hFFFFF)));
  endtask

  initial begin
    sb.reset_setup();
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: field extremes under the reset setup
    send_pixel(16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'h0000, 16'hFFFF);
    send_pixel(16'hFFFF, 16'h0000);
    send_pixel(16'd8192, 16'd8192);
    send_pixel(16'h5555, 16'hAAAA);
    send_pixel(16'hAAAA, 16'h5555);
    drain();
    // zero vector: focal zero at the image center; index beyond the map
    write_cfg(CFG_FOCAL_LENGTH, 48'd0);
    write_cfg(cfg_idx_t'(8'd200), 48'hFFFF_FFFF_FFFF);
    send_pixel(16'd8192, 16'd8192);
    send_pixel(16'd8193, 16'd8192);
    drain();
    // extremes: max pitch and focal, oversize resolution, saturating rotation
    write_cfg(CFG_PITCH_X, 48'hFFFFF);
    write_cfg(CFG_PITCH_Y, 48'hFFFFF);
    write_cfg(CFG_FOCAL_LENGTH, 48'hFFFFF);
    write_cfg(CFG_RESOLUTION_X, 48'h1FFF);
    write_cfg(CFG_RESOLUTION_Y, 48'd1);
    write_cfg(CFG_ROT_ROW0, 48'h7FFF_8000_7FFF);
    write_cfg(CFG_ROT_ROW1, 48'h7FFF_7FFF_8000);
    write_cfg(CFG_ROT_ROW2, 48'h8000_7FFF_7FFF);
    send_pixel(16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'h0000);
    send_pixel(16'h0000, 16'hFFFF);
    send_pixel(16'd1, 16'd8);
    drain();
    write_cfg(CFG_PITCH_X, 48'd0);
    write_cfg(CFG_PITCH_Y, 48'd1);
    write_cfg(CFG_FOCAL_LENGTH, 48'd1);
    send_pixel(16'h1234, 16'hFFFF);
    send_pixel(16'h0000, 16'h0000);
    drain();

    // random phases with varying idle patterns
    for (int ph = 0; ph < 8; ph++) begin
      random_setup();
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 49; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      if (ph == 5) begin
        // long receiver hold-off so the pipe backs up into the input
        fork
          begin
            hold_off = 1;
            repeat (200) @(negedge clk);
            hold_off = 0;
          end
          send_random(70);
        join
      end else send_random(65);
      drain();
    end

    if (sb.errors == 0) $display("tb_pinhole_ray_direction: clean");
    else $display("tb_pinhole_ray_direction: errors");
    $finish;
  end
endmodule
